[src/cbpa_pkg.sv]
// Shared constants and types for the 3x3 border-pass convolution core.
// Holds field widths, register reset values and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package cbpa_pkg;

   localparam int DEFAULT_MAX_WIDTH = 1024;
   localparam int MIN_SIZE          = 3;

   localparam int PIXEL_W    = 8;
   localparam int VALUE_W    = 20;
   localparam int MAXV_W     = 19;
   localparam int ROW_W      = 16;
   localparam int OUT_COL_W  = 10;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int IWIDTH_W   = 11;
   localparam int IHEIGHT_W  = 16;
   localparam int PROD_W     = 16;

   localparam int RSP_FIELDS_W = VALUE_W + ROW_W + OUT_COL_W + MAXV_W + ROW_W + OUT_COL_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   localparam logic [CSR_DATA_W-1:0] COEF_ROW0_RESET = 24'h00F800;
   localparam logic [CSR_DATA_W-1:0] COEF_ROW1_RESET = 24'h0800F8;
   localparam logic [CSR_DATA_W-1:0] COEF_ROW2_RESET = 24'h00F800;
   localparam logic [IWIDTH_W-1:0]   WIDTH_RESET     = 11'd8;
   localparam logic [IHEIGHT_W-1:0]  HEIGHT_RESET    = 16'd8;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_COEF_ROW0    = 3'd0,
      REG_COEF_ROW1    = 3'd1,
      REG_COEF_ROW2    = 3'd2,
      REG_IMAGE_WIDTH  = 3'd3,
      REG_IMAGE_HEIGHT = 3'd4
   } csr_index_type;

endpackage

[src/cbpa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the line buffers of the convolution core; depends on cbpa_pkg.
`timescale 1ns / 1ps

module cbpa_ram #(
   parameter int DATA_W = cbpa_pkg::PIXEL_W,
   parameter int DEPTH  = cbpa_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_W-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [DATA_W-1:0]          rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/conv3x3_border_pass_argmax_core.sv]
// 3x3 convolution over a raster pixel stream with border pass-through and argmax.
// Top level; depends on cbpa_pkg and cbpa_ram (two line buffers).
//
//  channel | dir | beat contents
//  req     | in  | tdata[7:0] pixel
//  rsp     | out | tdata: value, row, col, max value, max row, max col; tlast; tuser done
//  csr     | in  | csr_we, csr_addr (register index), csr_wdata (24 bits)
//
// One pixel per clock while each pixel yields at most one result and rsp_tready
// stays high; a pixel that yields two or three results (row ends, last row)
// holds req_tready low for the extra beats, since the result port moves at most
// one beat per clock.
// Synchronous reset clears position, running maximum and the pipe; the line
// buffers are not cleared. req_tready is low during a csr write and the clock after.
`timescale 1ns / 1ps

module conv3x3_border_pass_argmax_core #(
   parameter int MAX_WIDTH = cbpa_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [cbpa_pkg::PIXEL_W-1:0]        req_tdata,   // pixel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // conv_value, out_row, out_col, max_value, max_row, max_col, zero pad
   output logic [cbpa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,   // last_of_run
   output logic [0:0]                          rsp_tuser,   // image_done
   input  logic                                csr_we,
   input  logic [cbpa_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [cbpa_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int NSLOT = 4;
   localparam int SLOT_COL0 = 0;
   localparam int SLOT_CONV = 1;
   localparam int SLOT_LAST = 2;
   localparam int SLOT_OWN  = 3;

   typedef struct packed {
      logic [NSLOT-1:0]                 mask;
      logic                             clr;
      logic                             fend;
      logic [cbpa_pkg::PIXEL_W-1:0]     pix;
      logic [cbpa_pkg::PIXEL_W-1:0]     mid;
      logic [cbpa_pkg::ROW_W-1:0]       row;
      logic [COL_W-1:0]                 col;
   } item_type;

   // configuration
   logic [cbpa_pkg::CSR_DATA_W-1:0]  coef_ff [3];
   logic [cbpa_pkg::IWIDTH_W-1:0]    width_ff;
   logic [cbpa_pkg::IHEIGHT_W-1:0]   height_ff;
   logic                             cfg_hold_ff;

   // position
   logic [cbpa_pkg::ROW_W-1:0]       row_ff, row_in;
   logic [COL_W-1:0]                 col_ff, col_in;
   logic [WID_W-1:0]                 w_eff;
   logic [cbpa_pkg::IHEIGHT_W-1:0]   h_eff;
   logic [cbpa_pkg::ROW_W:0]         r_wrap, r_plus;
   logic [cbpa_pkg::ROW_W-1:0]       r_n;
   logic [COL_W-1:0]                 c_n, col_after, rd_addr;
   logic [WID_W-1:0]                 col_next1;
   logic                             clr_n, at_end, last_row, r_ge2;

   // line buffers and window
   logic [cbpa_pkg::PIXEL_W-1:0]     top_px, mid_px;
   logic [cbpa_pkg::PIXEL_W-1:0]     win_ff [3][3];

   // pipe
   logic                             fire, adv1, adv2, s1_free, bnd_ready;
   item_type                         s1_ff, s1_in, s2_ff, bnd_ff;
   logic signed [cbpa_pkg::PROD_W-1:0]  s2_prod_ff [9];
   logic signed [cbpa_pkg::PROD_W-1:0]  prod_in [9];
   logic signed [cbpa_pkg::VALUE_W-1:0] rsum [3];
   logic signed [cbpa_pkg::VALUE_W-1:0] conv_in, bnd_conv_ff;

   // emitter
   logic                             emit, e_last, e_done, take, earlier;
   logic [NSLOT-1:0]                 sel, rest;
   logic signed [cbpa_pkg::VALUE_W-1:0] e_val, base_s;
   logic [cbpa_pkg::ROW_W-1:0]       e_row, base_row;
   logic [COL_W-1:0]                 e_col, base_col;
   logic [cbpa_pkg::MAXV_W-1:0]      base_val;
   logic [cbpa_pkg::MAXV_W-1:0]      best_val_ff, best_val_in;
   logic [cbpa_pkg::ROW_W-1:0]       best_row_ff, best_row_in;
   logic [COL_W-1:0]                 best_col_ff, best_col_in;

   // result register
   logic                             rsp_valid_ff;
   logic signed [cbpa_pkg::VALUE_W-1:0] rsp_val_ff;
   logic [cbpa_pkg::ROW_W-1:0]       rsp_row_ff, rsp_mrow_ff;
   logic [COL_W-1:0]                 rsp_col_ff, rsp_mcol_ff;
   logic [cbpa_pkg::MAXV_W-1:0]      rsp_mval_ff;
   logic                             rsp_last_ff, rsp_done_ff;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0]  <= cbpa_pkg::COEF_ROW0_RESET;
         coef_ff[1]  <= cbpa_pkg::COEF_ROW1_RESET;
         coef_ff[2]  <= cbpa_pkg::COEF_ROW2_RESET;
         width_ff    <= cbpa_pkg::WIDTH_RESET;
         height_ff   <= cbpa_pkg::HEIGHT_RESET;
         cfg_hold_ff <= 1'b1;
      end else begin
         cfg_hold_ff <= csr_we;
         if (csr_we) begin
            case (cbpa_pkg::csr_index_type'(csr_addr))
               cbpa_pkg::REG_COEF_ROW0:    coef_ff[0] <= csr_wdata;
               cbpa_pkg::REG_COEF_ROW1:    coef_ff[1] <= csr_wdata;
               cbpa_pkg::REG_COEF_ROW2:    coef_ff[2] <= csr_wdata;
               cbpa_pkg::REG_IMAGE_WIDTH:  width_ff   <= csr_wdata[cbpa_pkg::IWIDTH_W-1:0];
               cbpa_pkg::REG_IMAGE_HEIGHT: height_ff  <= csr_wdata[cbpa_pkg::IHEIGHT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- position
   always_comb begin
      if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else if (32'(width_ff) < cbpa_pkg::MIN_SIZE) begin
         w_eff = WID_W'(cbpa_pkg::MIN_SIZE);
      end else begin
         w_eff = WID_W'(width_ff);
      end
      if (32'(height_ff) < cbpa_pkg::MIN_SIZE) begin
         h_eff = cbpa_pkg::IHEIGHT_W'(cbpa_pkg::MIN_SIZE);
      end else begin
         h_eff = height_ff;
      end

      // wrap a stale column or row left by a size change
      clr_n  = 1'b0;
      c_n    = col_ff;
      r_wrap = {1'b0, row_ff};
      if (WID_W'(col_ff) >= w_eff) begin
         c_n    = '0;
         r_wrap = {1'b0, row_ff} + 1'b1;
      end
      if (r_wrap >= {1'b0, h_eff}) begin
         c_n    = '0;
         r_wrap = '0;
         clr_n  = 1'b1;
      end
      r_n = r_wrap[cbpa_pkg::ROW_W-1:0];

      col_next1 = WID_W'(c_n) + 1'b1;
      at_end    = (col_next1 >= w_eff);
      r_plus    = {1'b0, r_n} + 1'b1;
      last_row  = (r_plus >= {1'b0, h_eff});
      r_ge2     = (r_n >= 16'd2);
      col_after = at_end ? '0 : col_next1[COL_W-1:0];

      col_in = col_after;
      if (at_end) begin
         row_in = last_row ? '0 : r_plus[cbpa_pkg::ROW_W-1:0];
      end else begin
         row_in = r_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (fire) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // ---------------------------------------------------------------- line buffers
   // read ahead for the pixel after this beat
   assign rd_addr = fire ? col_after : c_n;

   cbpa_ram #(
      .DATA_W (cbpa_pkg::PIXEL_W),
      .DEPTH  (MAX_WIDTH)
   ) u_line_two_above (
      .clock   (clock),
      .wr_en   (fire),
      .wr_addr (c_n),
      .wr_data (mid_px),
      .rd_addr (rd_addr),
      .rd_data (top_px)
   );

   cbpa_ram #(
      .DATA_W (cbpa_pkg::PIXEL_W),
      .DEPTH  (MAX_WIDTH)
   ) u_line_above (
      .clock   (clock),
      .wr_en   (fire),
      .wr_addr (c_n),
      .wr_data (req_tdata),
      .rd_addr (rd_addr),
      .rd_data (mid_px)
   );

   always_ff @(posedge clock) begin
      if (fire) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= win_ff[k][2];
         end
         win_ff[0][2] <= top_px;
         win_ff[1][2] <= mid_px;
         win_ff[2][2] <= req_tdata;
      end
   end

   // ---------------------------------------------------------------- pipe control
   assign adv2       = bnd_ready;
   assign adv1       = !(|s2_ff.mask) || adv2;
   assign s1_free    = !(|s1_ff.mask) || adv1;
   assign req_tready = s1_free && !csr_we && !cfg_hold_ff;
   assign fire       = req_tvalid && req_tready;

   always_comb begin
      s1_in.mask[SLOT_COL0] = r_ge2 && (c_n == '0);
      s1_in.mask[SLOT_CONV] = r_ge2 && (WID_W'(c_n) >= WID_W'(2));
      s1_in.mask[SLOT_LAST] = r_ge2 && at_end;
      s1_in.mask[SLOT_OWN]  = (r_n == '0) || (r_ge2 && last_row);
      s1_in.clr  = clr_n;
      s1_in.fend = at_end && last_row;
      s1_in.pix  = req_tdata;
      s1_in.mid  = mid_px;
      s1_in.row  = r_n;
      s1_in.col  = c_n;
   end

   // window in win_ff belongs to the item held in s1
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[3*k+j] = cbpa_pkg::PROD_W'($signed(coef_ff[k][8*j +: 8])
                                              * $signed({1'b0, win_ff[k][j]}));
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rsum[k] = cbpa_pkg::VALUE_W'(s2_prod_ff[3*k])
                 + cbpa_pkg::VALUE_W'(s2_prod_ff[3*k+1])
                 + cbpa_pkg::VALUE_W'(s2_prod_ff[3*k+2]);
      end
      conv_in = rsum[0] + rsum[1] + rsum[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff  <= '0;
         s2_ff  <= '0;
         bnd_ff <= '0;
      end else begin
         if (fire) begin
            s1_ff <= s1_in;
         end else if (adv1) begin
            s1_ff.mask <= '0;
         end
         if (adv1) begin
            s2_ff <= s1_ff;
         end
         if (adv2) begin
            bnd_ff <= s2_ff;
         end else if (emit) begin
            bnd_ff.mask <= rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s2_prod_ff <= prod_in;
      end
      if (adv2) begin
         bnd_conv_ff <= conv_in;
      end
   end

   // ---------------------------------------------------------------- emitter
   always_comb begin
      sel   = '0;
      e_val = $signed({8'b0, bnd_ff.pix, 4'b0});
      e_row = bnd_ff.row;
      e_col = bnd_ff.col;
      if (bnd_ff.mask[SLOT_COL0]) begin
         sel[SLOT_COL0] = 1'b1;
         e_val = $signed({8'b0, bnd_ff.mid, 4'b0});
         e_row = bnd_ff.row - 1'b1;
         e_col = '0;
      end else if (bnd_ff.mask[SLOT_CONV]) begin
         sel[SLOT_CONV] = 1'b1;
         e_val = bnd_conv_ff;
         e_row = bnd_ff.row - 1'b1;
         e_col = bnd_ff.col - 1'b1;
      end else if (bnd_ff.mask[SLOT_LAST]) begin
         sel[SLOT_LAST] = 1'b1;
         e_val = $signed({8'b0, bnd_ff.mid, 4'b0});
         e_row = bnd_ff.row - 1'b1;
      end else if (bnd_ff.mask[SLOT_OWN]) begin
         sel[SLOT_OWN] = 1'b1;
      end
      rest   = bnd_ff.mask & ~sel;
      e_last = (rest == '0);
      e_done = e_last && bnd_ff.fend;
      emit   = (|bnd_ff.mask) && (!rsp_valid_ff || rsp_tready);
      bnd_ready = !(|bnd_ff.mask) || (emit && e_last);

      // a frame restart clears the maximum before its first result
      base_val = bnd_ff.clr ? '0 : best_val_ff;
      base_row = bnd_ff.clr ? '0 : best_row_ff;
      base_col = bnd_ff.clr ? '0 : best_col_ff;
      base_s   = $signed({1'b0, base_val});
      earlier  = (e_row < base_row) || ((e_row == base_row) && (e_col < base_col));
      take     = (e_val > base_s)
              || ((e_val == base_s) && (e_val > 0) && earlier);
      best_val_in = take ? e_val[cbpa_pkg::MAXV_W-1:0] : base_val;
      best_row_in = take ? e_row : base_row;
      best_col_in = take ? e_col : base_col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_val_ff  <= '0;
         best_row_ff  <= '0;
         best_col_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            best_val_ff <= e_done ? '0 : best_val_in;
            best_row_ff <= e_done ? '0 : best_row_in;
            best_col_ff <= e_done ? '0 : best_col_in;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_val_ff  <= e_val;
         rsp_row_ff  <= e_row;
         rsp_col_ff  <= e_col;
         rsp_last_ff <= e_last;
         rsp_done_ff <= e_done;
         rsp_mval_ff <= best_val_in;
         rsp_mrow_ff <= best_row_in;
         rsp_mcol_ff <= best_col_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;
   assign rsp_tdata  = {{cbpa_pkg::RSP_PAD_W{1'b0}},
                        cbpa_pkg::OUT_COL_W'(rsp_mcol_ff),
                        rsp_mrow_ff,
                        rsp_mval_ff,
                        cbpa_pkg::OUT_COL_W'(rsp_col_ff),
                        rsp_row_ff,
                        rsp_val_ff};

`ifndef SYNTH
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("frame end beat without tlast");

   a_cfg_blocks_input: assert property (@(posedge clock) disable iff (reset)
      $past(csr_we) |-> !req_tready)
      else $error("pixel taken the clock after a csr write");

   a_max_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser[0] |-> best_val_ff == '0)
      else $error("running maximum not cleared at frame end");

   a_max_covers_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_val_ff[cbpa_pkg::VALUE_W-1]
      |-> {1'b0, rsp_mval_ff} >= rsp_val_ff[cbpa_pkg::VALUE_W-1:0])
      else $error("reported maximum below the value of its own beat");
`endif

endmodule
